@@ src/assert_macros.svh @@
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ src/ggm_pkg.sv @@
`timescale 1ns / 1ps

package ggm_pkg;

   localparam int DATA_WIDTH       = 16;
   localparam int FRAC_BITS        = 10;
   localparam int TANH_TABLE_DEPTH = 256;
   localparam int TAB_BITS         = $clog2(TANH_TABLE_DEPTH);

   // Internal fixed point: magnitudes carry 24 fraction bits.
   localparam int INT_FRAC = 24;
   localparam longint unsigned K_CUBIC   = 64'd192049463;
   localparam longint unsigned K_SQRT2PI = 64'd3426888095;
   localparam logic [15:0] TANH_ONE = 16'h8000;

   typedef logic [15:0] tanh_tab_type [0:TANH_TABLE_DEPTH];

   // Control word that travels beside the data through the pipeline.
   typedef struct packed {
      logic valid;
      logic x_neg;
      logic res_neg;
      logic row_end;
      logic batch_end;
   } ggm_ctl_type;

   // Unsigned quotient by shift and subtract, used only while the table is built.
   function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
      longint unsigned quo;
      logic [64:0]     rem;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // tanh(4k/DEPTH) in Q1.15, from a truncated Taylor sum of exp in Q32.
   function automatic tanh_tab_type build_tanh_tab();
      tanh_tab_type tab;
      longint unsigned e;
      longint unsigned term;
      longint unsigned num;
      longint unsigned den;
      longint unsigned n;
      for (int k = 0; k <= TANH_TABLE_DEPTH; k++) begin
         e    = 64'd1 << 32;
         term = 64'd1 << 32;
         for (n = 1; n < 400 && term != 0; n++) begin
            term = div_u64(term * (64'd8 * longint'(k)), longint'(TANH_TABLE_DEPTH) * n);
            e = e + term;
         end
         num = (e - (64'd1 << 32)) << 16;
         den = e + (64'd1 << 32);
         tab[k] = 16'(div_u64(num + den, 64'd2 * den));
      end
      return tab;
   endfunction

   localparam tanh_tab_type TANH_TAB = build_tanh_tab();

endpackage

@@ src/ggm_tanh_path.sv @@
`timescale 1ns / 1ps

// Six register stages from |x| to tanh(u(|x|)) in Q1.15.
module ggm_tanh_path
   import ggm_pkg::*;
(
   input  logic        clock,
   input  logic        advance,
   input  logic [16:0] a_mag,
   output logic [15:0] t_mag
);

   logic [12:0] a1_ff, a2_ff;
   logic        big1_ff, big2_ff, big3_ff, big4_ff;
   logic [25:0] sq_ff;
   logic [32:0] cube_ff;
   logic [30:0] inner_ff;
   logic [30:0] u_ff;
   logic [15:0] t0_ff, d_ff;
   logic [17:0] f_ff;
   logic        one_ff;
   logic [15:0] t_ff;

   logic [60:0]         cube_k_in;
   logic [62:0]         u_prod_in;
   logic [TAB_BITS-1:0] idx_in;
   logic [15:0]         t0_in, t1_in;
   logic [33:0]         interp_in;

   assign cube_k_in = 61'(cube_ff) * 61'(K_CUBIC);
   assign u_prod_in = 63'(inner_ff) * 63'(K_SQRT2PI);
   assign idx_in    = u_ff[INT_FRAC+1 -: TAB_BITS];
   assign t0_in     = TANH_TAB[idx_in];
   assign t1_in     = TANH_TAB[(TAB_BITS+1)'(idx_in) + 1'b1];
   assign interp_in = 34'(d_ff) * 34'(f_ff) + 34'(1 << 17);

   always_ff @(posedge clock) begin
      if (advance) begin
         // Magnitudes of eight and above saturate tanh to one.
         big1_ff <= (a_mag[16:13] != 4'd0);
         a1_ff   <= a_mag[12:0];
         sq_ff   <= 26'(a_mag[12:0]) * 26'(a_mag[12:0]);
         big2_ff <= big1_ff;
         a2_ff   <= a1_ff;
         cube_ff <= 33'((39'(sq_ff) * 39'(a1_ff)) >> 6);
         big3_ff <= big2_ff;
         inner_ff <= 31'({a2_ff, 14'd0}) + 31'(cube_k_in >> 32);
         big4_ff <= big3_ff;
         u_ff    <= 31'(u_prod_in >> 32);
         one_ff  <= big4_ff || (u_ff[30:INT_FRAC+2] != '0);
         t0_ff   <= t0_in;
         d_ff    <= (t1_in > t0_in) ? (t1_in - t0_in) : 16'd0;
         f_ff    <= u_ff[17:0];
         t_ff    <= one_ff ? TANH_ONE : (t0_ff + 16'(interp_in >> 18));
      end
   end

   assign t_mag = t_ff;

endmodule

@@ src/gelu_gated_multiply_unit.sv @@
`timescale 1ns / 1ps
// A word accepted on req_ passes the magnitude stage, the tanh stages, the
// product stage and the output register before it shows on rsp_.
// Throughput: one word per cycle; the whole pipeline holds while the output
// register is full and rsp_tready is low.
// Reset: synchronous and active high; it clears every valid bit, so no word
// is in flight afterwards. The tanh table is a constant and needs no fill.
module gelu_gated_multiply_unit
   import ggm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [15:0] x_value, [31:16] y_value
   input  logic        req_tlast,  // end_of_row
   input  logic        req_tuser,  // end_of_batch
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // [15:0] gated_value, [16] saturated, rest zero
   output logic        rsp_tlast,  // row_done
   output logic        rsp_tuser   // batch_done
);

   // Stage 0 holds the magnitudes, the tanh path adds six stages, stage 7
   // forms the final product and stage 8 is the output register.
   localparam int LAST = 8;
   localparam int T_STAGE = 6;

   ggm_ctl_type ctl_ff [0:LAST];
   ggm_ctl_type ctl0_in;
   logic        advance;

   logic [16:0] ax_ff, ay_ff;
   logic [30:0] m_ff [1:T_STAGE];
   logic [47:0] prod_ff;
   logic [15:0] val_ff;
   logic        sat_ff;

   logic [16:0] x_ext, y_ext;
   logic [15:0] t_mag;
   logic [16:0] op_in;
   logic [21:0] q_in;
   logic [15:0] val_in;
   logic        sat_in;

   // The pipeline moves as one whenever the output register can be freed.
   assign advance    = !ctl_ff[LAST].valid || rsp_tready;
   assign req_tready = advance;

   assign x_ext = 17'(signed'(req_tdata[15:0]));
   assign y_ext = 17'(signed'(req_tdata[31:16]));

   always_comb begin
      ctl0_in.valid     = req_tvalid;
      ctl0_in.x_neg     = req_tdata[15];
      ctl0_in.res_neg   = req_tdata[15] ^ req_tdata[31];
      ctl0_in.row_end   = req_tlast;
      ctl0_in.batch_end = req_tuser;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LAST; i++) begin
            ctl_ff[i].valid <= 1'b0;
         end
      end else if (advance) begin
         ctl_ff[0] <= ctl0_in;
         for (int i = 1; i <= LAST; i++) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
      end
   end

   // Magnitudes, then |x|*|y| delayed until tanh is ready.
   always_ff @(posedge clock) begin
      if (advance) begin
         ax_ff   <= req_tdata[15] ? 17'(-x_ext) : x_ext;
         ay_ff   <= req_tdata[31] ? 17'(-y_ext) : y_ext;
         m_ff[1] <= 31'(34'(ax_ff) * 34'(ay_ff));
         for (int i = 2; i <= T_STAGE; i++) begin
            m_ff[i] <= m_ff[i-1];
         end
      end
   end

   ggm_tanh_path u_tanh (
      .clock   (clock),
      .advance (advance),
      .a_mag   (ax_ff),
      .t_mag   (t_mag)
   );

   // 0.5*(1 + tanh) scaled to Q1.16 is one plus or minus t in Q1.15.
   assign op_in = ctl_ff[T_STAGE].x_neg ? (17'h08000 - 17'(t_mag))
                                        : (17'h08000 + 17'(t_mag));

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= 48'(m_ff[T_STAGE]) * 48'(op_in);
      end
   end

   // Round half up on the magnitude, then clip to the signed range.
   always_comb begin
      q_in   = 22'((prod_ff + 48'(1 << 25)) >> 26);
      sat_in = 1'b0;
      val_in = 16'(q_in);
      if (ctl_ff[LAST-1].res_neg) begin
         if (q_in > 22'h008000) begin
            sat_in = 1'b1;
            val_in = 16'h8000;
         end else begin
            val_in = 16'(-q_in);
         end
      end else if (q_in > 22'h007fff) begin
         sat_in = 1'b1;
         val_in = 16'h7fff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         val_ff <= val_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_tvalid = ctl_ff[LAST].valid;
   assign rsp_tdata  = {7'd0, sat_ff, val_ff};
   assign rsp_tlast  = ctl_ff[LAST].row_end;
   assign rsp_tuser  = ctl_ff[LAST].batch_end;

endmodule

@@ src/ggm_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ggm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "rsp word changed while stalled")
   `ASSERT_CLK(a_flow, clock, reset, rsp_tready |-> req_tready, "input blocked although output drains")
   `ASSERT_CLK(a_sat_bound, clock, reset, rsp_tvalid && rsp_tdata[16] |-> rsp_tdata[15:0] == 16'h7fff || rsp_tdata[15:0] == 16'h8000, "saturated word not at a bound")
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "word left after reset")

endmodule

bind gelu_gated_multiply_unit ggm_checker u_ggm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Stream bench for the gated GELU multiply unit. Each word offered on req_
// is predicted with an independent fixed-point model of y * gelu(x) and the
// prediction is queued; every word leaving rsp_ is checked against the
// oldest queued prediction.
module tb_top;
   import ggm_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int PIPE_DRAIN  = 20;

   typedef struct packed {
      logic [23:0] data;
      logic        row_done;
      logic        batch_done;
   } gated_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;  // [15:0] x_value, [31:16] y_value
   logic        req_tlast = 1'b0;  // end_of_row
   logic        req_tuser = 1'b0;  // end_of_batch
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;  // [15:0] gated_value, [16] saturated, rest zero
   logic        rsp_tlast;  // row_done
   logic        rsp_tuser;  // batch_done

   gated_word_type expected_words[$];
   logic [15:0]    tanh_q15 [0:TANH_TABLE_DEPTH];
   int             mismatch_count = 0;
   int             cycle_count = 0;
   bit             idling_on = 1'b1;
   int             rsp_hold_cycles = 0;

   gelu_gated_multiply_unit DUT (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // The tanh table: tanh(4k/DEPTH) in Q1.15 from a truncated Taylor sum of exp.
   initial begin
      longint unsigned e_sum, term, num, den;
      for (int k = 0; k <= TANH_TABLE_DEPTH; k++) begin
         e_sum = 64'd1 << 32;
         term  = 64'd1 << 32;
         for (longint unsigned n = 1; n < 400 && term != 0; n++) begin
            term  = term * (64'd8 * k) / (TANH_TABLE_DEPTH * n);
            e_sum = e_sum + term;
         end
         num = (e_sum - (64'd1 << 32)) << 16;
         den = e_sum + (64'd1 << 32);
         tanh_q15[k] = 16'((num + den) / (2 * den));
      end
   end

   // Magnitude of tanh(u(|x|)) in Q1.15, with u computed at 24 fraction bits.
   function automatic longint unsigned tanh_of_mag(longint unsigned mag);
      longint unsigned xm, sq, cube, inner, u, pos, idx, frac, t0, t1, step;
      if (mag >= (64'd8 << FRAC_BITS)) return 64'd32768;
      xm    = mag << (24 - FRAC_BITS);
      sq    = (xm * xm) >> 24;
      cube  = (sq * xm) >> 24;
      inner = xm + ((cube * 64'd192049463) >> 32);
      u     = (inner * 64'd3426888095) >> 32;
      if (u >= (64'd4 << 24)) return 64'd32768;
      pos  = u * TANH_TABLE_DEPTH;
      idx  = pos >> 26;
      frac = pos & ((64'd1 << 26) - 1);
      if (idx >= TANH_TABLE_DEPTH) return 64'd32768;
      t0   = tanh_q15[idx];
      t1   = tanh_q15[idx + 1];
      step = (t1 > t0) ? t1 - t0 : 0;
      return t0 + ((step * frac + (64'd1 << 25)) >> 26);
   endfunction

   function automatic gated_word_type gelu_gate_predict(logic [15:0] x, logic [15:0] y,
                                                        logic row_end, logic batch_end);
      gated_word_type w;
      longint unsigned ax, ay, t, op, q;
      logic [15:0] val;
      logic sat;
      ax  = x[15] ? 64'h10000 - x : x;
      ay  = y[15] ? 64'h10000 - y : y;
      t   = tanh_of_mag(ax);
      op  = x[15] ? 64'd32768 - t : 64'd32768 + t;
      q   = (ax * ay * op + (64'd1 << (FRAC_BITS + 15))) >> (FRAC_BITS + 16);
      sat = 1'b0;
      if (x[15] != y[15]) begin
         if (q > 32768) begin
            q = 32768;
            sat = 1'b1;
         end
         val = 16'(-q);
      end else begin
         if (q > 32767) begin
            q = 32767;
            sat = 1'b1;
         end
         val = 16'(q);
      end
      w.data       = {7'd0, sat, val};
      w.row_done   = row_end;
      w.batch_done = batch_end;
      return w;
   endfunction

   // Offers one word, with a random idle burst first while idling is on. The
   // prediction is queued at the edge at which the word is taken.
   task automatic send_word(logic [15:0] x, logic [15:0] y, logic row_end,
                            logic batch_end);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {y, x};
      req_tlast  <= row_end;
      req_tuser  <= batch_end;
      do @(posedge clock); while (!req_tready);
      expected_words.push_back(gelu_gate_predict(x, y, row_end, batch_end));
   endtask

   // Magnitudes are mostly small so that the tanh table is well exercised.
   function automatic logic [15:0] random_value();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return 16'($signed($urandom_range(0, 16383)) - 8192);
         default: return 16'($signed($urandom_range(0, 8191)) - 4096);
      endcase
   endfunction

   task automatic send_random_words(int count);
      for (int i = 0; i < count; i++)
         send_word(random_value(), random_value(), ($urandom_range(0, 7) == 0),
                   ($urandom_range(0, 31) == 0));
   endtask

   // Field extremes, the tanh saturation regions, zero, and clipping both ways.
   task automatic test_directed_extremes();
      send_word(16'h0000, 16'h0000, 1'b0, 1'b0);
      send_word(16'h7FFF, 16'h7FFF, 1'b1, 1'b0);
      send_word(16'h8000, 16'h8000, 1'b0, 1'b1);
      send_word(16'h7FFF, 16'h8000, 1'b1, 1'b1);
      send_word(16'h8000, 16'h7FFF, 1'b0, 1'b0);
      send_word(16'h0400, 16'h0400, 1'b0, 1'b0);   // x = 1.0, y = 1.0
      send_word(16'hFC00, 16'h0400, 1'b0, 1'b0);   // x = -1.0
      send_word(16'h2000, 16'h0400, 1'b0, 1'b0);   // x exactly 8.0
      send_word(16'h1FFF, 16'h0400, 1'b0, 1'b0);   // just below 8.0
      send_word(16'hE000, 16'h0400, 1'b0, 1'b0);   // x = -8.0
      send_word(16'h0D60, 16'h0400, 1'b0, 1'b0);   // u just above four
      send_word(16'h0C00, 16'hFC00, 1'b0, 1'b0);   // u near four, negative gate
      send_word(16'h0001, 16'h0001, 1'b0, 1'b0);
      send_word(16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
      send_word(16'h5000, 16'h1000, 1'b0, 1'b0);   // clips high
      send_word(16'h5000, 16'hF000, 1'b0, 1'b0);   // clips low
      send_word(16'h4000, 16'hF800, 1'b1, 1'b0);   // exactly the negative bound
      send_word(16'h0200, 16'h5555, 1'b0, 1'b0);
      send_word(16'hAAAA, 16'h5555, 1'b1, 1'b1);
      send_word(16'hF800, 16'hF800, 1'b0, 1'b1);
   endtask

   // The receiver holds off for a long stretch while words keep coming.
   task automatic test_output_backpressure();
      rsp_hold_cycles = 300;
      send_random_words(60);
   endtask

   task automatic test_random_stream();
      send_random_words(1700);
   endtask

   // Back-to-back words with no idling on either side.
   task automatic test_full_rate_tail();
      idling_on = 1'b0;
      send_random_words(100);
   endtask

   // Receiver: random stall bursts, a long hold on request, none at the end.
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold_cycles = rsp_hold_cycles - 1;
         end else if (idling_on && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11) - 1) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Result checker: compares each word taken with the oldest prediction.
   always @(posedge clock) begin
      gated_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected result word: data %h last %b user %b",
                        rsp_tdata, rsp_tlast, rsp_tuser);
         end else begin
            want = expected_words.pop_front();
            if (rsp_tdata !== want.data || rsp_tlast !== want.row_done ||
                rsp_tuser !== want.batch_done) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Mismatch: expected data %h last %b user %b, got %h %b %b",
                           want.data, want.row_done, want.batch_done,
                           rsp_tdata, rsp_tlast, rsp_tuser);
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      test_output_backpressure();
      test_random_stream();
      test_full_rate_tail();
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
